// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Every form is clocked on clk and is
// switched off while rst is high.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define GLD_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// The consequent must hold in the same cycle as the antecedent.
`define GLD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GLD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/gld_pkg.sv
// ----------------------------------------------------------------------------
// gld_pkg
// Types, constants and table functions of the Gregorian to lunar date unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gld_pkg;

  localparam int FIRST_YEAR     = 1900;
  localparam int ROM_ENTRIES    = 151;
  localparam int CYCLE_BASE     = 1864;
  localparam int EPOCH_SHIFT    = 30;
  localparam int YEAR_BASE_DAYS = 348;
  localparam int MAX_GREG_YEAR  = FIRST_YEAR + ROM_ENTRIES;
  localparam int DAYS_W         = 16;
  localparam int RAW_DAYS_W     = 17;
  localparam int YIDX_W         = 8;
  localparam int LEN_W          = 9;
  localparam int SHORT_MONTH    = 29;
  localparam int LONG_MONTH     = 30;
  localparam int LAST_MONTH     = 12;
  localparam int STEM_COUNT     = 10;
  localparam int BRANCH_COUNT   = 12;
  localparam logic [3:0] STEM_INIT   = 4'((FIRST_YEAR - CYCLE_BASE) % STEM_COUNT);
  localparam logic [3:0] BRANCH_INIT = 4'((FIRST_YEAR - CYCLE_BASE) % BRANCH_COUNT);

  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } greg_date_t;

  typedef struct packed {
    logic [11:0] lun_year;
    logic [3:0]  lun_month;
    logic [4:0]  lun_day;
    logic        leap_flag;
    logic [3:0]  stem_index;
    logic [3:0]  branch_index;
    logic        range_error;
  } lunar_date_t;

  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] days;
  } day_count_t;

  typedef struct packed {
    logic              less;
    logic [DAYS_W-1:0] diff;
  } sub_res_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_DONE
  } gld_state_t;

  // Bits 15..4 flag 30-day months 1..12, bit 16 flags a 30-day leap month,
  // bits 3..0 hold the month that the leap month follows.
  localparam logic [16:0] YEAR_ROM [0:ROM_ENTRIES-1] = '{
    17'h04bd8, 17'h04ae0, 17'h0a570, 17'h054d5, 17'h0d260, 17'h0d950, 17'h16554,
    17'h056a0, 17'h09ad0, 17'h055d2, 17'h04ae0, 17'h0a5b6, 17'h0a4d0, 17'h0d250,
    17'h1d255, 17'h0b540, 17'h0d6a0, 17'h0ada2, 17'h095b0, 17'h14977, 17'h04970,
    17'h0a4b0, 17'h0b4b5, 17'h06a50, 17'h06d40, 17'h1ab54, 17'h02b60, 17'h09570,
    17'h052f2, 17'h04970, 17'h06566, 17'h0d4a0, 17'h0ea50, 17'h06e95, 17'h05ad0,
    17'h02b60, 17'h186e3, 17'h092e0, 17'h1c8d7, 17'h0c950, 17'h0d4a0, 17'h1d8a6,
    17'h0b550, 17'h056a0, 17'h1a5b4, 17'h025d0, 17'h092d0, 17'h0d2b2, 17'h0a950,
    17'h0b557, 17'h06ca0, 17'h0b550, 17'h15355, 17'h04da0, 17'h0a5d0, 17'h14573,
    17'h052d0, 17'h0a9a8, 17'h0e950, 17'h06aa0, 17'h0aea6, 17'h0ab50, 17'h04b60,
    17'h0aae4, 17'h0a570, 17'h05260, 17'h0f263, 17'h0d950, 17'h05b57, 17'h056a0,
    17'h096d0, 17'h04dd5, 17'h04ad0, 17'h0a4d0, 17'h0d4d4, 17'h0d250, 17'h0d558,
    17'h0b540, 17'h0b5a0, 17'h195a6, 17'h095b0, 17'h049b0, 17'h0a974, 17'h0a4b0,
    17'h0b27a, 17'h06a50, 17'h06d40, 17'h0af46, 17'h0ab60, 17'h09570, 17'h04af5,
    17'h04970, 17'h064b0, 17'h074a3, 17'h0ea50, 17'h06b58, 17'h055c0, 17'h0ab60,
    17'h096d5, 17'h092e0, 17'h0c960, 17'h0d954, 17'h0d4a0, 17'h0da50, 17'h07552,
    17'h056a0, 17'h0abb7, 17'h025d0, 17'h092d0, 17'h0cab5, 17'h0a950, 17'h0b4a0,
    17'h0baa4, 17'h0ad50, 17'h055d9, 17'h04ba0, 17'h0a5b0, 17'h15176, 17'h052b0,
    17'h0a930, 17'h07954, 17'h06aa0, 17'h0ad50, 17'h05b52, 17'h04b60, 17'h0a6e6,
    17'h0a4e0, 17'h0d260, 17'h0ea65, 17'h0d530, 17'h05aa0, 17'h076a3, 17'h096d0,
    17'h04bd7, 17'h04ad0, 17'h0a4d0, 17'h1d0b6, 17'h0d250, 17'h0d520, 17'h0dd45,
    17'h0b5a0, 17'h056d0, 17'h055b2, 17'h049b0, 17'h0a577, 17'h0a4b0, 17'h0aa50,
    17'h1b255, 17'h06d20, 17'h0ada0, 17'h14b63
  };

  function automatic logic [16:0] year_info(input logic [YIDX_W-1:0] idx);
    logic [16:0] w;
    w = '0;
    if (int'(idx) < ROM_ENTRIES) begin
      w = YEAR_ROM[idx];
    end
    return w;
  endfunction

  function automatic logic [3:0] leap_base(input logic [16:0] w);
    return (w[3:0] > 4'(LAST_MONTH)) ? 4'd0 : w[3:0];
  endfunction

  function automatic logic [4:0] leap_len(input logic [16:0] w);
    logic [4:0] len;
    len = '0;
    if (leap_base(w) != 4'd0) begin
      len = w[16] ? 5'(LONG_MONTH) : 5'(SHORT_MONTH);
    end
    return len;
  endfunction

  function automatic logic [4:0] mon_len(input logic [16:0] w, input logic [3:0] m);
    logic [4:0] idx;
    idx = 5'd16 - 5'(m);
    return w[idx] ? 5'(LONG_MONTH) : 5'(SHORT_MONTH);
  endfunction

  function automatic logic [LEN_W-1:0] year_len(input logic [16:0] w);
    logic [3:0] cnt;
    cnt = '0;
    for (int i = 4; i < 16; i++) begin
      cnt = cnt + 4'(w[i]);
    end
    return LEN_W'(YEAR_BASE_DAYS) + LEN_W'(cnt) + LEN_W'(leap_len(w));
  endfunction

  function automatic logic [4:0] greg_month_len(input logic [3:0] m);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

// File: design/gld_in_if.sv
// ----------------------------------------------------------------------------
// gld_in_if
// Valid/ready channel that carries one Gregorian date per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gld_in_if;
  logic                valid;
  logic                ready;
  gld_pkg::greg_date_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/gld_out_if.sv
// ----------------------------------------------------------------------------
// gld_out_if
// Valid/ready channel that carries one lunar date result per beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface gld_out_if;
  logic                 valid;
  logic                 ready;
  gld_pkg::lunar_date_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: design/gld_day_count.sv
// ----------------------------------------------------------------------------
// gld_day_count
// Checks a Gregorian date and counts its days from the first day of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gld_day_count (
  input  gld_pkg::greg_date_t date,
  output gld_pkg::day_count_t count
);

  logic [11:0]                     year_off;
  logic [7:0]                      k;
  logic                            year_ok;
  logic                            month_ok;
  logic                            leap_year;
  logic [4:0]                      mlen;
  logic [gld_pkg::RAW_DAYS_W-1:0]  leaps;
  logic [gld_pkg::RAW_DAYS_W-1:0]  raw;

  // Inside the span of the table the century rule only excludes 1900,
  // so a year is a leap year when its offset is a nonzero multiple of four.
  always_comb begin
    year_off  = date.greg_year - 12'(gld_pkg::FIRST_YEAR);
    k         = year_off[7:0];
    year_ok   = (date.greg_year >= 12'(gld_pkg::FIRST_YEAR))
             && (date.greg_year <= 12'(gld_pkg::MAX_GREG_YEAR));
    month_ok  = (date.greg_month != 4'd0) && (date.greg_month <= 4'd12);
    leap_year = (k[1:0] == 2'd0) && (k != 8'd0);
    mlen      = gld_pkg::greg_month_len(date.greg_month)
              + 5'((date.greg_month == 4'd2) && leap_year);
    leaps     = (k == 8'd0) ? '0 : gld_pkg::RAW_DAYS_W'((k - 8'd1) >> 2);
    raw       = gld_pkg::RAW_DAYS_W'(k) * gld_pkg::RAW_DAYS_W'(365)
              + leaps
              + gld_pkg::RAW_DAYS_W'(gld_pkg::days_before_month(date.greg_month))
              + gld_pkg::RAW_DAYS_W'((date.greg_month > 4'd2) && leap_year)
              + gld_pkg::RAW_DAYS_W'(date.greg_day)
              - gld_pkg::RAW_DAYS_W'(1);
    count.ok   = year_ok && month_ok && (date.greg_day != 5'd0)
              && (date.greg_day <= mlen)
              && (raw >= gld_pkg::RAW_DAYS_W'(gld_pkg::EPOCH_SHIFT));
    count.days = gld_pkg::DAYS_W'(raw - gld_pkg::RAW_DAYS_W'(gld_pkg::EPOCH_SHIFT));
  end

endmodule

`default_nettype wire

// File: design/gld_sub_unit.sv
// ----------------------------------------------------------------------------
// gld_sub_unit
// Shared compare and subtract unit that takes a year or month length off the
// remaining day count.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gld_sub_unit (
  input  logic [gld_pkg::DAYS_W-1:0] minuend,
  input  logic [gld_pkg::LEN_W-1:0]  subtrahend,
  output gld_pkg::sub_res_t          res
);

  logic [gld_pkg::DAYS_W:0] diff;

  always_comb begin
    diff     = {1'b0, minuend} - (gld_pkg::DAYS_W + 1)'(subtrahend);
    res.less = diff[gld_pkg::DAYS_W];
    res.diff = diff[gld_pkg::DAYS_W-1:0];
  end

endmodule

`default_nettype wire

// File: design/gregorian_to_lunar_date_unit.sv
// ----------------------------------------------------------------------------
// gregorian_to_lunar_date_unit
// Converts a Gregorian date to the Chinese lunar date with leap flag and the
// stem and branch indices of the lunar year.
// ----------------------------------------------------------------------------
//
//   Channel   Role     Beat
//   greg      sink     Gregorian year, month and day
//   lunar     source   lunar year, month, day, leap flag, stem, branch, error
//
// After the accepting edge a date walks the lunar years from 1900 up to its own,
// then the month steps in its year (at most 13), and ends in the done state,
// where the result register loads; a date that fails the day count goes from
// the idle state straight to the done state.
// Every step uses the one shared subtract unit. Reset clears the sequencer and
// the result valid flag. A finished result waits in the done state while the
// result register is full; greg is ready only in the idle state.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module gregorian_to_lunar_date_unit #(
  parameter int TABLE_YEARS = 151
) (
  input  logic   clk,
  input  logic   rst,
  gld_in_if.sink   greg,
  gld_out_if.source lunar
);

  localparam int SPAN = (TABLE_YEARS < gld_pkg::ROM_ENTRIES) ? TABLE_YEARS
                                                            : gld_pkg::ROM_ENTRIES;

  gld_pkg::gld_state_t state, state_next;

  logic [gld_pkg::DAYS_W-1:0] days, days_next;
  logic [gld_pkg::YIDX_W-1:0] yi, yi_next;
  logic [3:0]                 mon, mon_next;
  logic                       leap_slot, leap_slot_next;
  logic                       leap_hit, leap_hit_next;
  logic                       err, err_next;
  logic [3:0]                 stem, stem_next;
  logic [3:0]                 branch, branch_next;

  logic                       out_valid;
  gld_pkg::lunar_date_t       out_data;
  gld_pkg::lunar_date_t       result;
  logic                       load;

  gld_pkg::day_count_t        dcount;
  gld_pkg::sub_res_t          sub;
  logic [16:0]                info;
  logic [gld_pkg::LEN_W-1:0]  len;
  logic                       last_year;

  gld_day_count u_day_count (
    .date  (greg.data),
    .count (dcount)
  );

  gld_sub_unit u_sub_unit (
    .minuend    (days),
    .subtrahend (len),
    .res        (sub)
  );

  always_comb begin
    info      = gld_pkg::year_info(yi);
    last_year = ((gld_pkg::YIDX_W + 1)'(yi) + 9'd1) >= 9'(SPAN);
    if (state == gld_pkg::ST_YEAR) begin
      len = gld_pkg::year_len(info);
    end else if (leap_slot) begin
      len = gld_pkg::LEN_W'(gld_pkg::leap_len(info));
    end else begin
      len = gld_pkg::LEN_W'(gld_pkg::mon_len(info, mon));
    end
    load = (state == gld_pkg::ST_DONE) && (!out_valid || lunar.ready);
  end

  always_comb begin
    state_next = state;
    unique case (state)
      gld_pkg::ST_IDLE: begin
        if (greg.valid) begin
          state_next = dcount.ok ? gld_pkg::ST_YEAR : gld_pkg::ST_DONE;
        end
      end
      gld_pkg::ST_YEAR: begin
        if (sub.less) begin
          state_next = gld_pkg::ST_MONTH;
        end else if (last_year) begin
          state_next = gld_pkg::ST_DONE;
        end
      end
      gld_pkg::ST_MONTH: begin
        if (sub.less || (mon == 4'(gld_pkg::LAST_MONTH)
            && (leap_slot || mon != gld_pkg::leap_base(info)))) begin
          state_next = gld_pkg::ST_DONE;
        end
      end
      gld_pkg::ST_DONE: begin
        if (load) begin
          state_next = gld_pkg::ST_IDLE;
        end
      end
      default: state_next = gld_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    days_next      = days;
    yi_next        = yi;
    mon_next       = mon;
    leap_slot_next = leap_slot;
    leap_hit_next  = leap_hit;
    err_next       = err;
    stem_next      = stem;
    branch_next    = branch;
    greg.ready     = 1'b0;
    unique case (state)
      gld_pkg::ST_IDLE: begin
        greg.ready     = 1'b1;
        days_next      = dcount.days;
        yi_next        = '0;
        mon_next       = 4'd1;
        leap_slot_next = 1'b0;
        leap_hit_next  = 1'b0;
        err_next       = !dcount.ok;
        stem_next      = gld_pkg::STEM_INIT;
        branch_next    = gld_pkg::BRANCH_INIT;
      end
      gld_pkg::ST_YEAR: begin
        if (!sub.less) begin
          days_next = sub.diff;
          if (last_year) begin
            err_next = 1'b1;
          end else begin
            yi_next     = yi + gld_pkg::YIDX_W'(1);
            stem_next   = (stem == 4'(gld_pkg::STEM_COUNT - 1)) ? 4'd0 : stem + 4'd1;
            branch_next = (branch == 4'(gld_pkg::BRANCH_COUNT - 1)) ? 4'd0
                                                                    : branch + 4'd1;
          end
        end
      end
      gld_pkg::ST_MONTH: begin
        if (sub.less) begin
          leap_hit_next = leap_slot;
        end else begin
          days_next = sub.diff;
          if (!leap_slot && mon == gld_pkg::leap_base(info)) begin
            leap_slot_next = 1'b1;
          end else if (mon == 4'(gld_pkg::LAST_MONTH)) begin
            days_next = '0;
          end else begin
            mon_next       = mon + 4'd1;
            leap_slot_next = 1'b0;
          end
        end
      end
      gld_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    result = '0;
    if (err) begin
      result.range_error = 1'b1;
    end else begin
      result.lun_year     = 12'(gld_pkg::FIRST_YEAR) + 12'(yi);
      result.lun_month    = mon;
      result.lun_day      = days[4:0] + 5'd1;
      result.leap_flag    = leap_hit;
      result.stem_index   = stem;
      result.branch_index = branch;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gld_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (lunar.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    days      <= days_next;
    yi        <= yi_next;
    mon       <= mon_next;
    leap_slot <= leap_slot_next;
    leap_hit  <= leap_hit_next;
    err       <= err_next;
    stem      <= stem_next;
    branch    <= branch_next;
    if (load) begin
      out_data <= result;
    end
  end

  assign lunar.valid = out_valid;
  assign lunar.data  = out_data;

  `GLD_ASSERT_IMPL(a_err_clears_fields, lunar.valid && lunar.data.range_error,
    lunar.data.lun_year == 12'd0 && lunar.data.lun_month == 4'd0
    && lunar.data.lun_day == 5'd0 && !lunar.data.leap_flag,
    "Error result carries nonzero date fields.")
  `GLD_ASSERT_IMPL(a_date_in_range, lunar.valid && !lunar.data.range_error,
    lunar.data.lun_day != 5'd0 && lunar.data.lun_day <= 5'd30
    && lunar.data.lun_month != 4'd0 && lunar.data.lun_month <= 4'd12,
    "Lunar month or day out of range.")
  `GLD_ASSERT_IMPL(a_year_index, state == gld_pkg::ST_YEAR, 9'(yi) < 9'(SPAN),
    "Year walk ran past the table.")
  `GLD_ASSERT_NEXT(a_busy_after_beat, greg.valid && greg.ready, !greg.ready,
    "Accepted a date while another is in work.")

endmodule

`default_nettype wire
